/* hdl/lwbc_pkg.sv */
// Shared types and codes of the LRU write-back block cache directory.
`default_nettype none
package lwbc_pkg;
    localparam int DRIVE_W  = 8;
    localparam int SECTOR_W = 32;

    // request types on the port
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;   // unused code, answered with done

    // result actions
    localparam logic [2:0] ACT_HIT   = 3'd0;
    localparam logic [2:0] ACT_FILL  = 3'd1;
    localparam logic [2:0] ACT_ALLOC = 3'd2;
    localparam logic [2:0] ACT_WB    = 3'd3;
    localparam logic [2:0] ACT_DONE  = 3'd4;

    typedef enum logic [1:0] {
        K_READ  = 2'd0,
        K_WRITE = 2'd1,
        K_FLUSH = 2'd2,
        K_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [DRIVE_W-1:0]    drive;
        logic [SECTOR_W-1:0]   sector;
        logic                  flush_every;
        logic                  drop_valid;
    } req_t;
endpackage
`default_nettype wire

/* hdl/lwbc_front.sv */
// Request intake: classifies requests and queues them for the engine.
`default_nettype none
module lwbc_front
    import lwbc_pkg::*;
#(
    parameter int SECTOR_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [1:0]          req_type,
    input  wire logic [DRIVE_W-1:0]  drive,
    input  wire logic [SECTOR_W-1:0] sector,
    input  wire logic                flush_every,
    input  wire logic                drop_valid,
    output logic                     busy,
    output logic                     q_empty,
    output req_t                     q_head,
    input  wire logic                pop
);
    localparam int TW = (SECTOR_BITS < SECTOR_W) ? SECTOR_BITS : SECTOR_W;

    req_t       mem_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    req_t       cls;

    always_comb
    begin
        case (req_type)
            REQ_READ:  cls.kind = K_READ;
            REQ_WRITE: cls.kind = K_WRITE;
            REQ_FLUSH: cls.kind = K_FLUSH;
            default:   cls.kind = K_NONE;
        endcase
        cls.drive       = drive;
        cls.sector      = SECTOR_W'(sector[TW-1:0]);
        cls.flush_every = flush_every;
        cls.drop_valid  = drop_valid;
    end

    assign busy    = (cnt_reg == 2'd2);
    assign q_empty = (cnt_reg == 2'd0);
    assign q_head  = mem_reg[rd_reg];
    assign push    = start && !busy;

    always_comb
    begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

/* hdl/lwbc_engine.sv */
// Directory engine: tag match, LRU order, allocation, eviction and flush walk.
`default_nettype none
module lwbc_engine
    import lwbc_pkg::*;
#(
    parameter int ENTRIES     = 32,
    parameter int SECTOR_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_empty,
    input  req_t                     q_head,
    output logic                     pop,
    output logic                     strobe,
    output logic [2:0]               action,
    output logic [4:0]               entry_index,
    output logic [DRIVE_W-1:0]       out_drive,
    output logic [SECTOR_W-1:0]      out_sector,
    output logic                     last
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW = $clog2(ENTRIES + 1);
    localparam int TW = (SECTOR_BITS < SECTOR_W) ? SECTOR_BITS : SECTOR_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOOK = 5'b00010,
        S_FILL = 5'b00100,
        S_WALK = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    logic [TW-1:0]       tag_sector_reg [ENTRIES];
    logic [DRIVE_W-1:0]  tag_drive_reg  [ENTRIES];
    logic [IW-1:0]       rank_reg [ENTRIES];
    logic [IW-1:0]       rank_next [ENTRIES];
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [ENTRIES-1:0]  dirty_reg, dirty_next;
    logic [FW-1:0]       fc_reg, fc_next;
    logic                aw_reg, aw_next;
    logic [IW-1:0]       walk_reg, walk_next;
    logic [IW-1:0]       victim_reg, victim_next;

    logic                strobe_next, last_next;
    logic [2:0]          action_next;
    logic [4:0]          index_next;
    logic [DRIVE_W-1:0]  drive_next;
    logic [SECTOR_W-1:0] sector_next;

    logic [ENTRIES-1:0]  hv;
    logic                hit;
    logic [IW-1:0]       hidx, tidx, tgt;
    logic                is_w, do_touch, do_ins, do_alloc;
    logic [IW-1:0]       tgt_rank;

    // associative match and LRU tail, both one-hot so an OR picks the index
    always_comb
    begin
        hidx = '0;
        tidx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hv[i] = valid_reg[i] && tag_drive_reg[i] == req_reg.drive
                    && tag_sector_reg[i] == req_reg.sector[TW-1:0];
            if (hv[i])
            begin
                hidx = hidx | IW'(i);
            end
            if (rank_reg[i] == LAST_IDX)
            begin
                tidx = tidx | IW'(i);
            end
        end
        hit = |hv;
    end

    assign is_w = (req_reg.kind == K_WRITE);

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        valid_next  = valid_reg;
        dirty_next  = dirty_reg;
        fc_next     = fc_reg;
        aw_next     = aw_reg;
        walk_next   = walk_reg;
        victim_next = victim_reg;
        pop         = 1'b0;
        do_touch    = 1'b0;
        do_ins      = 1'b0;
        do_alloc    = 1'b0;
        tgt         = hidx;
        strobe_next = 1'b0;
        action_next = ACT_DONE;
        index_next  = '0;
        drive_next  = '0;
        sector_next = '0;
        last_next   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    req_next = q_head;
                    if (q_head.kind == K_READ || q_head.kind == K_WRITE)
                    begin
                        state_next = S_LOOK;
                    end
                    else if (q_head.kind == K_FLUSH && aw_reg)
                    begin
                        state_next = S_WALK;
                        walk_next  = '0;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_LOOK:
            begin
                if (hit)
                begin
                    if (is_w)
                    begin
                        dirty_next[hidx] = 1'b1;
                        aw_next          = 1'b1;
                    end
                    do_touch    = 1'b1;
                    tgt         = hidx;
                    strobe_next = 1'b1;
                    action_next = ACT_HIT;
                    index_next  = 5'(hidx);
                    drive_next  = req_reg.drive;
                    sector_next = req_reg.sector;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (fc_reg != '0)
                begin
                    fc_next  = fc_reg - 1'b1;
                    tgt      = IW'(fc_reg - 1'b1);
                    do_ins   = 1'b1;
                    do_alloc = 1'b1;
                end
                else if (valid_reg[tidx] && dirty_reg[tidx])
                begin
                    // old contents go out before the new block comes in
                    strobe_next = 1'b1;
                    action_next = ACT_WB;
                    index_next  = 5'(tidx);
                    drive_next  = tag_drive_reg[tidx];
                    sector_next = SECTOR_W'(tag_sector_reg[tidx]);
                    victim_next = tidx;
                    state_next  = S_FILL;
                end
                else
                begin
                    tgt      = tidx;
                    do_touch = 1'b1;
                    do_alloc = 1'b1;
                end
            end
            S_FILL:
            begin
                tgt      = victim_reg;
                do_touch = 1'b1;
                do_alloc = 1'b1;
            end
            S_WALK:
            begin
                if (valid_reg[walk_reg] && dirty_reg[walk_reg])
                begin
                    strobe_next          = 1'b1;
                    action_next          = ACT_WB;
                    index_next           = 5'(walk_reg);
                    drive_next           = tag_drive_reg[walk_reg];
                    sector_next          = SECTOR_W'(tag_sector_reg[walk_reg]);
                    dirty_next[walk_reg] = 1'b0;
                end
                if (valid_reg[walk_reg] && dirty_reg[walk_reg] && !req_reg.flush_every)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    if (req_reg.drop_valid)
                    begin
                        valid_next[walk_reg] = 1'b0;
                    end
                    if (walk_reg == LAST_IDX)
                    begin
                        aw_next    = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        walk_next = walk_reg + 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                strobe_next = 1'b1;
                action_next = ACT_DONE;
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_alloc)
        begin
            valid_next[tgt] = 1'b1;
            dirty_next[tgt] = is_w;
            if (is_w)
            begin
                aw_next = 1'b1;
            end
            strobe_next = 1'b1;
            action_next = is_w ? ACT_ALLOC : ACT_FILL;
            index_next  = 5'(tgt);
            drive_next  = req_reg.drive;
            sector_next = req_reg.sector;
            last_next   = 1'b1;
            state_next  = S_IDLE;
        end
    end

    // recency update over the allocated entries
    assign tgt_rank = rank_reg[tgt];

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (do_touch && FW'(i) >= fc_reg && rank_reg[i] < tgt_rank)
            begin
                rank_next[i] = rank_reg[i] + 1'b1;
            end
            if (do_ins && FW'(i) >= fc_next && IW'(i) != tgt)
            begin
                rank_next[i] = rank_reg[i] + 1'b1;
            end
        end
        if (do_touch || do_ins)
        begin
            rank_next[tgt] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        walk_reg    <= walk_next;
        victim_reg  <= victim_next;
        action      <= action_next;
        entry_index <= index_next;
        out_drive   <= drive_next;
        out_sector  <= sector_next;
        last        <= last_next;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_reg[i] <= rank_next[i];
        end
        if (do_alloc)
        begin
            tag_drive_reg[tgt]  <= req_reg.drive;
            tag_sector_reg[tgt] <= req_reg.sector[TW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            dirty_reg <= '0;
            fc_reg    <= FW'(ENTRIES);
            aw_reg    <= 1'b1;
            strobe    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            fc_reg    <= fc_next;
            aw_reg    <= aw_next;
            strobe    <= strobe_next;
        end
    end

    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= FW'(ENTRIES))
        else $error("free count above entry count");
    a_fill_after_wb: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FILL |-> strobe && action == ACT_WB && !last)
        else $error("eviction fill without prior write back");
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && action == ACT_DONE |-> last && entry_index == '0)
        else $error("done result malformed");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == S_IDLE && !q_empty)
        else $error("queue popped while engine busy");
endmodule
`default_nettype wire

/* hdl/lru_writeback_block_cache_directory_unit.sv */
// Top level of the LRU write-back block cache directory.
//
// Usage:
//   A request (req_type, drive, sector, flush_every, drop_valid) is taken
//   at a rising edge with start high and busy low. Requests enter a two-deep
//   queue, so a new one is taken while the engine is still working on an
//   earlier one; busy rises only when that queue is full.
//   Each result (action, entry_index, out_drive, out_sector, last) is shown
//   for one cycle with strobe high. The receiver cannot stall, so results
//   are simply presented; last marks the final result of a request.
// Result order:
//   Read or write: a dirty victim is written back before the fill result.
//   Flush: the walk visits one entry per cycle, ending at the last entry
//   or, without flush_every, at the first dirty one; a skipped flush or
//   unknown type only gives done. The flush walk over the entries sets the
//   worst case per request.
// Reset:
//   All entries free and clean, nothing valid, the "written" flag set so the
//   first flush walks. Tags and recency are loaded when an entry is taken.
`default_nettype none
module lru_writeback_block_cache_directory_unit
    import lwbc_pkg::*;
#(
    parameter int ENTRIES     = 32,
    parameter int SECTOR_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          req_type,
    input  wire logic [DRIVE_W-1:0]  drive,
    input  wire logic [SECTOR_W-1:0] sector,
    input  wire logic                flush_every,
    input  wire logic                drop_valid,
    output logic                     strobe,
    output logic [2:0]               action,
    output logic [4:0]               entry_index,
    output logic [DRIVE_W-1:0]       out_drive,
    output logic [SECTOR_W-1:0]      out_sector,
    output logic                     last
);
    // queue handoff between intake and engine
    logic q_empty;
    req_t q_head;
    logic pop;

    lwbc_front #(
        .SECTOR_BITS(SECTOR_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req_type    (req_type),
        .drive       (drive),
        .sector      (sector),
        .flush_every (flush_every),
        .drop_valid  (drop_valid),
        .busy        (busy),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .pop         (pop)
    );

    lwbc_engine #(
        .ENTRIES    (ENTRIES),
        .SECTOR_BITS(SECTOR_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .pop         (pop),
        .strobe      (strobe),
        .action      (action),
        .entry_index (entry_index),
        .out_drive   (out_drive),
        .out_sector  (out_sector),
        .last        (last)
    );
endmodule
`default_nettype wire
